/* hdl/cfae_pkg.sv */
`timescale 1ns / 1ps

package cfae_pkg;

    localparam int MAX_DATA_BYTES_DEF = 8;

    localparam int STEP_W = 5;

    // Encoder step numbers
    localparam logic [STEP_W-1:0] STEP_TYPE   = 5'd0;
    localparam logic [STEP_W-1:0] STEP_ID_EXT = 5'd1;
    localparam logic [STEP_W-1:0] STEP_ID_STD = 5'd6;
    localparam logic [STEP_W-1:0] STEP_DLC    = 5'd9;
    localparam logic [STEP_W-1:0] STEP_DATA   = 5'd10;
    localparam logic [STEP_W-1:0] STEP_STAMP  = 5'd26;
    localparam logic [STEP_W-1:0] STEP_CR     = 5'd30;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_A   = 8'h41;
    localparam logic [7:0] CHAR_T_U = 8'h54;
    localparam logic [7:0] CHAR_T_L = 8'h74;
    localparam logic [7:0] CHAR_R_U = 8'h52;
    localparam logic [7:0] CHAR_R_L = 8'h72;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic              load;
        logic              emit;
        logic              last;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic       ext;
        logic       rtr;
        logic [3:0] nbytes;
        logic       out_free;
    } t_dp_status;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v > 4'd9) begin
            c = CHAR_A + 8'(v) - 8'd10;
        end else begin
            c = CHAR_0 + 8'(v);
        end
        return c;
    endfunction

endpackage

/* hdl/cfae_if.sv */
`timescale 1ns / 1ps

interface cfae_frame_if;
    logic        valid;
    logic        ready;
    logic [28:0] frame_id;
    logic        is_extended;
    logic        is_remote;
    logic [3:0]  length_code;
    logic [63:0] payload;
    logic [15:0] stamp;

    modport source (output valid, frame_id, is_extended, is_remote, length_code, payload,
                    stamp, input ready);
    modport sink (input valid, frame_id, is_extended, is_remote, length_code, payload,
                  stamp, output ready);
endinterface

interface cfae_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ascii_char;
    logic       end_of_line;

    modport source (output valid, ascii_char, end_of_line, input ready);
    modport sink (input valid, ascii_char, end_of_line, output ready);
endinterface

interface cfae_cfg_if;
    logic valid;
    logic ready;
    logic timestamp_enable;

    modport source (output valid, timestamp_enable, input ready);
    modport sink (input valid, timestamp_enable, output ready);
endinterface

/* hdl/cfae_ctrl.sv */
`timescale 1ns / 1ps

module cfae_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_frame_valid,
    output logic                o_frame_ready,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_data,
    input  cfae_pkg::t_dp_status i_status,
    output cfae_pkg::t_dp_cmd    o_cmd
);
    import cfae_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_ts_en;
    logic              last_step;
    logic [STEP_W-1:0] adv_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_TYPE;
            r_ts_en <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_valid) begin
                r_ts_en <= i_cfg_data;
            end
        end
    end

    // Carriage return closes the line once the timestamp digits are done or skipped
    assign last_step = (r_step >= STEP_STAMP) && (!r_ts_en || r_step == STEP_CR);

    always_comb begin
        adv_step = r_step + 5'd1;
        if (r_step == STEP_TYPE) begin
            adv_step = i_status.ext ? STEP_ID_EXT : STEP_ID_STD;
        end else if (r_step == STEP_DLC) begin
            if (i_status.rtr || i_status.nbytes == 4'd0) begin
                adv_step = STEP_STAMP;
            end
        end else if (r_step >= STEP_DATA && r_step < STEP_STAMP) begin
            // skip to the timestamp after the last data digit
            if (5'(r_step - STEP_DLC) >= {i_status.nbytes, 1'b0}) begin
                adv_step = STEP_STAMP;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_frame_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.out_free && last_step) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_frame_ready = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.emit    = 1'b0;
        o_cmd.last    = last_step;
        o_cmd.step    = r_step;
        n_step        = r_step;
        unique case (r_state)
            ST_IDLE: begin
                o_frame_ready = 1'b1;
                o_cmd.load    = i_frame_valid;
                n_step        = STEP_TYPE;
            end
            ST_RUN: begin
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free) begin
                    n_step = last_step ? STEP_TYPE : adv_step;
                end
            end
            default: n_step = STEP_TYPE;
        endcase
    end

endmodule

/* hdl/cfae_dpath.sv */
`timescale 1ns / 1ps

module cfae_dpath #(
    parameter int MAX_DATA_BYTES = cfae_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cfae_pkg::t_dp_cmd    i_cmd,
    output cfae_pkg::t_dp_status o_status,
    input  logic [28:0]          i_frame_id,
    input  logic                 i_is_extended,
    input  logic                 i_is_remote,
    input  logic [3:0]           i_length_code,
    input  logic [63:0]          i_payload,
    input  logic [15:0]          i_stamp,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_ascii_char,
    output logic                 o_end_of_line
);
    import cfae_pkg::*;

    localparam logic [3:0] MaxBytes = 4'(MAX_DATA_BYTES);

    logic [28:0] r_id;
    logic [63:0] r_payload;
    logic [15:0] r_stamp;
    logic        r_ext;
    logic        r_rtr;
    logic [3:0]  r_dlc;
    logic        r_valid;
    logic [7:0]  r_char;
    logic        r_eol;

    logic [31:0] id_wide;
    logic [2:0]  id_k;
    logic [3:0]  data_k;
    logic [1:0]  stamp_k;
    logic [3:0]  nibble;
    logic [7:0]  n_char;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id      <= i_frame_id;
            r_payload <= i_payload;
            r_stamp   <= i_stamp;
            r_ext     <= i_is_extended;
            r_rtr     <= i_is_remote;
            r_dlc     <= i_length_code;
        end
        if (i_cmd.emit) begin
            r_char <= n_char;
            r_eol  <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign id_wide = {3'b000, r_id};
    assign id_k    = 3'(i_cmd.step - STEP_ID_EXT);
    assign data_k  = 4'(i_cmd.step - STEP_DATA);
    assign stamp_k = 2'(i_cmd.step - STEP_STAMP);

    // Most significant nibble first: nibble k sits at shift 4*(last - k)
    always_comb begin
        if (i_cmd.step < STEP_DLC) begin
            nibble = 4'(id_wide >> {~id_k, 2'b00});
        end else if (i_cmd.step == STEP_DLC) begin
            nibble = r_dlc;
        end else if (i_cmd.step < STEP_STAMP) begin
            nibble = 4'(r_payload >> {~data_k, 2'b00});
        end else begin
            nibble = 4'(r_stamp >> {~stamp_k, 2'b00});
        end
    end

    always_comb begin
        if (i_cmd.last) begin
            n_char = CHAR_CR;
        end else if (i_cmd.step == STEP_TYPE) begin
            if (r_ext) begin
                n_char = r_rtr ? CHAR_R_U : CHAR_T_U;
            end else begin
                n_char = r_rtr ? CHAR_R_L : CHAR_T_L;
            end
        end else begin
            n_char = hex_char(nibble);
        end
    end

    assign o_status.ext      = r_ext;
    assign o_status.rtr      = r_rtr;
    assign o_status.nbytes   = (r_dlc > MaxBytes) ? MaxBytes : r_dlc;
    assign o_status.out_free = !r_valid || i_ready;

    assign o_valid       = r_valid;
    assign o_ascii_char  = r_char;
    assign o_end_of_line = r_eol;

endmodule

/* hdl/can_frame_ascii_encoder_unit.sv */
`timescale 1ns / 1ps
// After the frame transfer, the type letter is registered into the output register
// once that register is free. Throughput: one character per cycle from the step
// sequencer while the receiver accepts, for a frame of 6 to 31 characters; the next
// frame is taken while the carriage return still waits in the output register.
// Reset (synchronous, active low) empties the output register, idles the
// sequencer and clears the timestamp enable.

module can_frame_ascii_encoder_unit #(
    parameter int MAX_DATA_BYTES = cfae_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cfae_frame_if.sink   i_frame,
    cfae_cfg_if.sink     i_cfg,
    cfae_char_if.source  o_char
);
    import cfae_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       frame_ready;

    assign i_cfg.ready   = 1'b1;
    assign i_frame.ready = frame_ready;

    cfae_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (i_frame.valid),
        .o_frame_ready (frame_ready),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.timestamp_enable),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    cfae_dpath #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_frame_id    (i_frame.frame_id),
        .i_is_extended (i_frame.is_extended),
        .i_is_remote   (i_frame.is_remote),
        .i_length_code (i_frame.length_code),
        .i_payload     (i_frame.payload),
        .i_stamp       (i_frame.stamp),
        .o_valid       (o_char.valid),
        .i_ready       (o_char.ready),
        .o_ascii_char  (o_char.ascii_char),
        .o_end_of_line (o_char.end_of_line)
    );

endmodule

/* hdl/cfae_checker.sv */
`timescale 1ns / 1ps

module cfae_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_frame_valid,
    input logic       i_frame_ready,
    input logic       i_char_valid,
    input logic       i_char_ready,
    input logic [7:0] i_ascii_char,
    input logic       i_end_of_line
);
    import cfae_pkg::*;

    // a stalled character holds
    a_char_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_char_valid && !i_char_ready |=>
            i_char_valid && $stable(i_ascii_char) && $stable(i_end_of_line))
        else $error("stalled character changed");

    a_busy_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame_valid && i_frame_ready |=> !i_frame_ready)
        else $error("frame taken while a line is in progress");

    a_eol_is_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_char_valid && i_end_of_line |-> i_ascii_char == CHAR_CR)
        else $error("end of line on a character other than carriage return");

    a_cr_only_at_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_char_valid && !i_end_of_line |-> i_ascii_char != CHAR_CR)
        else $error("carriage return without end of line");

endmodule

bind can_frame_ascii_encoder_unit cfae_checker u_cfae_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_frame_valid (i_frame.valid),
    .i_frame_ready (i_frame.ready),
    .i_char_valid  (o_char.valid),
    .i_char_ready  (o_char.ready),
    .i_ascii_char  (o_char.ascii_char),
    .i_end_of_line (o_char.end_of_line)
);

/* sim/tb_can_frame_ascii_encoder_unit.sv */
`timescale 1ns / 1ps

module tb_can_frame_ascii_encoder_unit;
    import cfae_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_FRAMES = 48;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [28:0] id;
        logic        ext;
        logic        rem;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic [15:0] stamp;
    } t_can_frame;

    typedef struct {
        logic [7:0] ch;
        logic       eol;
    } t_line_char;

    logic clk;
    logic rst_n;

    cfae_frame_if frame_bus();
    cfae_cfg_if   cfg_bus();
    cfae_char_if  char_bus();

    t_line_char pending_line_chars[$];
    logic       stamp_enabled;
    int         mismatch_count;
    int         cycle_count;
    int         send_idle_pct;
    int         recv_stall_pct;

    can_frame_ascii_encoder_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_frame (frame_bus),
        .i_cfg   (cfg_bus),
        .o_char  (char_bus)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("can_frame_ascii_encoder_unit regression: fail");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge clk) begin
        char_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        t_line_char want;
        if (rst_n && char_bus.valid && char_bus.ready) begin
            if (pending_line_chars.size() == 0) begin
                $display("%0t: unexpected char, expected none actual %h eol %b",
                         $time, char_bus.ascii_char, char_bus.end_of_line);
                mismatch_count++;
            end else begin
                want = pending_line_chars.pop_front();
                if (char_bus.ascii_char !== want.ch) begin
                    $display("%0t: ascii_char mismatch, expected %h actual %h",
                             $time, want.ch, char_bus.ascii_char);
                    mismatch_count++;
                end
                if (char_bus.end_of_line !== want.eol) begin
                    $display("%0t: end_of_line mismatch, expected %b actual %b",
                             $time, want.eol, char_bus.end_of_line);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic logic [7:0] ascii_nibble(logic [3:0] v);
        return (v > 4'd9) ? (CHAR_A + 8'(v - 4'd10)) : (CHAR_0 + 8'(v));
    endfunction

    function automatic void queue_char(logic [7:0] ch, logic eol);
        t_line_char c;
        c.ch = ch;
        c.eol = eol;
        pending_line_chars.push_back(c);
    endfunction

    // Append the full text line that one frame produces
    function automatic void encode_line(t_can_frame f, logic ts_en);
        logic [31:0] id_word;
        int          nbytes;
        id_word = {3'b000, f.id};
        if (f.ext) begin
            queue_char(f.rem ? CHAR_R_U : CHAR_T_U, 1'b0);
            for (int k = 7; k >= 0; k--) queue_char(ascii_nibble(id_word[4*k +: 4]), 1'b0);
        end else begin
            queue_char(f.rem ? CHAR_R_L : CHAR_T_L, 1'b0);
            for (int k = 2; k >= 0; k--) queue_char(ascii_nibble(id_word[4*k +: 4]), 1'b0);
        end
        queue_char(ascii_nibble(f.dlc), 1'b0);
        nbytes = (int'(f.dlc) > MAX_DATA_BYTES_DEF) ? MAX_DATA_BYTES_DEF : int'(f.dlc);
        if (!f.rem) begin
            for (int b = 0; b < nbytes; b++) begin
                queue_char(ascii_nibble(f.data[8*(7-b)+4 +: 4]), 1'b0);
                queue_char(ascii_nibble(f.data[8*(7-b) +: 4]), 1'b0);
            end
        end
        if (ts_en) begin
            for (int k = 3; k >= 0; k--) queue_char(ascii_nibble(f.stamp[4*k +: 4]), 1'b0);
        end
        queue_char(CHAR_CR, 1'b1);
    endfunction

    function automatic t_can_frame make_frame(logic [28:0] id, logic ext, logic rem,
                                              logic [3:0] dlc, logic [63:0] data,
                                              logic [15:0] stamp);
        t_can_frame f;
        f.id = id;
        f.ext = ext;
        f.rem = rem;
        f.dlc = dlc;
        f.data = data;
        f.stamp = stamp;
        return f;
    endfunction

    function automatic t_can_frame random_frame();
        t_can_frame f;
        int         sel;
        sel = $urandom_range(99);
        f.id = 29'($urandom);
        f.ext = 1'($urandom_range(1));
        f.rem = ($urandom_range(99) < 20);
        if (sel < 10) f.dlc = 4'd0;
        else if (sel < 80) f.dlc = 4'($urandom_range(8, 1));
        else f.dlc = 4'($urandom_range(15, 9));
        f.data = {$urandom, $urandom};
        f.stamp = 16'($urandom);
        return f;
    endfunction

    // Called and returns at a falling edge
    task automatic send_frame(t_can_frame f);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            frame_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_bus.valid       <= 1'b1;
        frame_bus.frame_id    <= f.id;
        frame_bus.is_extended <= f.ext;
        frame_bus.is_remote   <= f.rem;
        frame_bus.length_code <= f.dlc;
        frame_bus.payload     <= f.data;
        frame_bus.stamp       <= f.stamp;
        do @(posedge clk); while (!frame_bus.ready);
        encode_line(f, stamp_enabled);
        @(negedge clk);
    endtask

    task automatic write_timestamp_enable(logic en);
        cfg_bus.valid            <= 1'b1;
        cfg_bus.timestamp_enable <= en;
        do @(posedge clk); while (!cfg_bus.ready);
        stamp_enabled = en;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Drop valid, wait for every queued char, then let the pipeline settle
    task automatic drain_lines();
        frame_bus.valid <= 1'b0;
        while (pending_line_chars.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random_phase(int send_pct, int recv_pct, logic ts_en);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        write_timestamp_enable(ts_en);
        repeat (PHASE_FRAMES) send_frame(random_frame());
        drain_lines();
    endtask

    task automatic test_directed_plain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_timestamp_enable(1'b0);
        send_frame(make_frame(29'h0, 1'b0, 1'b0, 4'd0, 64'h0, 16'h0));
        send_frame(make_frame(29'h7FF, 1'b0, 1'b0, 4'd8, '1, 16'hFFFF));
        send_frame(make_frame(29'h1FFFFFFF, 1'b0, 1'b0, 4'd1, 64'h0123456789ABCDEF, 16'h0));
        send_frame(make_frame(29'h123, 1'b0, 1'b1, 4'd8, '1, 16'h0));
        // DLC above the cap: digit as given, eight bytes of data
        send_frame(make_frame(29'h456, 1'b0, 1'b0, 4'd15, 64'hFEDCBA9876543210, 16'h0));
        send_frame(make_frame(29'h789, 1'b0, 1'b0, 4'd9, 64'h0F1E2D3C4B5A6978, 16'h0));
        send_frame(make_frame(29'h1FFFFFFF, 1'b1, 1'b0, 4'd8, 64'h0, 16'h0));
        send_frame(make_frame(29'h0, 1'b1, 1'b0, 4'd0, '1, 16'h0));
        send_frame(make_frame(29'h12345678, 1'b1, 1'b1, 4'd4, 64'h1122334455667788, 16'h0));
        send_frame(make_frame(29'h0ABCDEF0, 1'b1, 1'b0, 4'd12, 64'hA5A5A5A5A5A5A5A5, 16'h0));
        send_frame(make_frame(29'h10000000, 1'b1, 1'b1, 4'd0, 64'h0, 16'h0));
        drain_lines();
    endtask

    task automatic test_directed_timestamp();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_timestamp_enable(1'b1);
        send_frame(make_frame(29'h0, 1'b0, 1'b0, 4'd0, 64'h0, 16'h0000));
        send_frame(make_frame(29'h7FF, 1'b0, 1'b0, 4'd8, '1, 16'hFFFF));
        // longest line
        send_frame(make_frame(29'h1FFFFFFF, 1'b1, 1'b0, 4'd8, 64'h5A5A5A5A5A5A5A5A, 16'hA5C3));
        send_frame(make_frame(29'h0F0F0F0F, 1'b1, 1'b1, 4'd15, '1, 16'h1234));
        send_frame(make_frame(29'h3C5, 1'b0, 1'b1, 4'd0, '1, 16'h5A0F));
        send_frame(make_frame(29'h15555555, 1'b1, 1'b0, 4'd15, '1, 16'hFFFF));
        send_frame(make_frame(29'h0AAAAAAA, 1'b0, 1'b0, 4'd3, 64'h8000000000000001, 16'h8001));
        drain_lines();
    endtask

    task automatic test_random_no_idle();
        run_random_phase(0, 0, 1'b1);
    endtask

    task automatic test_random_sender_idle();
        run_random_phase(85, 0, 1'b0);
    endtask

    task automatic test_random_receiver_stall();
        run_random_phase(0, 85, 1'b1);
    endtask

    task automatic test_random_both_idle();
        run_random_phase(7, 7, 1'($urandom_range(1)));
    endtask

    initial begin
        rst_n                    = 1'b0;
        frame_bus.valid          = 1'b0;
        frame_bus.frame_id       = '0;
        frame_bus.is_extended    = 1'b0;
        frame_bus.is_remote      = 1'b0;
        frame_bus.length_code    = '0;
        frame_bus.payload        = '0;
        frame_bus.stamp          = '0;
        cfg_bus.valid            = 1'b0;
        cfg_bus.timestamp_enable = 1'b0;
        char_bus.ready           = 1'b0;
        stamp_enabled            = 1'b0;
        mismatch_count           = 0;
        cycle_count              = 0;
        send_idle_pct            = 0;
        recv_stall_pct           = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_plain();
        test_directed_timestamp();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        drain_lines();

        if (mismatch_count == 0) begin
            $display("can_frame_ascii_encoder_unit regression: pass");
        end else begin
            $display("can_frame_ascii_encoder_unit regression: fail");
        end
        $finish;
    end

endmodule
